FILE: src/kci_pkg.sv
// Shared types, constants and codes of the keyframe curve interpolator.
`timescale 1ns / 1ps
`default_nettype none

package kci_pkg;

	localparam int MAX_KEYS_DEF = 64;
	localparam int NUM_COMP     = 3;
	localparam int FRAME_W      = 16;
	localparam int VALUE_W      = 32;
	localparam int QUERY_W      = 25;
	localparam int KIDX_W       = 6;
	localparam int KCOUNT_W     = 7;
	localparam int FRAC_W       = 16;
	localparam int APB_AW       = 3;
	localparam int APB_DW       = 32;

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	localparam logic REG_KEY_COUNT  = 1'b0;
	localparam logic REG_COLOR_MODE = 1'b1;

	typedef struct packed {
		logic               hold;
		logic [FRAME_W-1:0] frame;
		logic [VALUE_W-1:0] va;
		logic [VALUE_W-1:0] vb;
		logic [VALUE_W-1:0] vc;
	} key_entry_t;

	typedef enum logic [1:0] {
		ADDR_FIRST,
		ADDR_LAST,
		ADDR_SCAN
	} rd_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_FIRST,
		ST_CHK_FIRST,
		ST_RD_LAST,
		ST_CHK_LAST,
		ST_RD_SCAN,
		ST_CHK_SCAN,
		ST_SEG,
		ST_DIV,
		ST_MUL,
		ST_ACC,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic    key_write;
		logic    query_load;
		rd_sel_t rd_sel;
		logic    left_load;
		logic    right_load;
		logic    res_from_rd;
		logic    res_from_left;
		logic    scan_clear;
		logic    scan_inc;
		logic    div_start;
		logic    div_step;
		logic    comp_clear;
		logic    mul_go;
		logic    acc_go;
		logic    out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic q_le_rd;
		logic q_ge_rd;
		logic q_lt_rd;
		logic scan_at_last;
		logic seg_flat;
		logic div_done;
		logic comp_done;
		logic out_busy;
	} dp_status_t;

endpackage

`default_nettype wire

FILE: src/keyframe_curve_interpolator_core.sv
// Top level of the keyframe curve interpolator: registers, controller and datapath.
// A key write is taken in the idle state; the next item may follow in the next cycle.
// A query checks the first key, then the last; at or below the first or at or above the last
// it returns that key's values. Else it scans for the right key; a hold or flat segment gives
// the left key's values, else 16 divider steps and a blend follow; a stalled result waits.
// Reset clears control and send state; key count resets to 1. Unwritten keys are undefined.
`timescale 1ns / 1ps
`default_nettype none

module keyframe_curve_interpolator_core
	import kci_pkg::*;
#(
	parameter int MAX_KEYS = MAX_KEYS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic                       func,
	input  wire logic        [KIDX_W-1:0]   key_index,
	input  wire logic        [FRAME_W-1:0]  key_frame,
	input  wire logic                       key_hold,
	input  wire logic signed [VALUE_W-1:0]  key_value_a,
	input  wire logic signed [VALUE_W-1:0]  key_value_b,
	input  wire logic signed [VALUE_W-1:0]  key_value_c,
	input  wire logic signed [QUERY_W-1:0]  query_frame,
	input  wire logic                       force_send,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic signed      [VALUE_W-1:0]  value_a,
	output logic signed      [VALUE_W-1:0]  value_b,
	output logic signed      [VALUE_W-1:0]  value_c,
	output logic                            send_now,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic        [APB_AW-1:0]   paddr,
	input  wire logic        [APB_DW-1:0]   pwdata,
	output logic             [APB_DW-1:0]   prdata,
	output logic                            pready
);

	logic [KCOUNT_W-1:0] key_count;
	logic                color_mode;
	dp_cmd_t             cmd;
	dp_status_t          status;

	kci_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.key_count (key_count),
		.color_mode(color_mode)
	);

	kci_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.func    (func),
		.in_ready(in_ready),
		.cmd     (cmd),
		.status  (status)
	);

	kci_datapath #(
		.MAX_KEYS(MAX_KEYS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.key_index  (key_index),
		.key_frame  (key_frame),
		.key_hold   (key_hold),
		.key_value_a(key_value_a),
		.key_value_b(key_value_b),
		.key_value_c(key_value_c),
		.query_frame(query_frame),
		.force_send (force_send),
		.key_count  (key_count),
		.color_mode (color_mode),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.value_a    (value_a),
		.value_b    (value_b),
		.value_c    (value_c),
		.send_now   (send_now)
	);

endmodule

`default_nettype wire

FILE: src/kci_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module kci_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: src/kci_regs.sv
// APB configuration registers: key count and colour mode.
`timescale 1ns / 1ps
`default_nettype none

module kci_regs
	import kci_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [APB_AW-1:0]   paddr,
	input  wire logic [APB_DW-1:0]   pwdata,
	output logic      [APB_DW-1:0]   prdata,
	output logic                     pready,
	output logic      [KCOUNT_W-1:0] key_count,
	output logic                     color_mode
);

	logic [KCOUNT_W-1:0] key_count_q;
	logic                color_mode_q;
	logic                wr_en;
	logic                reg_idx;

	assign reg_idx = paddr[2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q  <= KCOUNT_W'(1);
			color_mode_q <= 1'b0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_KEY_COUNT:  key_count_q  <= pwdata[KCOUNT_W-1:0];
				REG_COLOR_MODE: color_mode_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_KEY_COUNT:  prdata = APB_DW'(key_count_q);
			REG_COLOR_MODE: prdata = APB_DW'(color_mode_q);
			default:        prdata = '0;
		endcase
	end

	assign key_count  = key_count_q;
	assign color_mode = color_mode_q;

endmodule

`default_nettype wire

FILE: src/kci_ctrl.sv
// Controller state machine sequencing table writes, segment search, divide and blend.
`timescale 1ns / 1ps
`default_nettype none

module kci_ctrl
	import kci_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic       func,
	output logic            in_ready,
	output dp_cmd_t         cmd,
	input  wire dp_status_t status
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.rd_sel = ADDR_SCAN;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (func == FUNC_QUERY) begin
						cmd.query_load = 1'b1;
						state_d        = ST_RD_FIRST;
					end else begin
						cmd.key_write = 1'b1;
					end
				end
			end
			ST_RD_FIRST: begin
				cmd.rd_sel = ADDR_FIRST;
				state_d    = ST_CHK_FIRST;
			end
			ST_CHK_FIRST: begin
				if (status.q_le_rd) begin
					cmd.res_from_rd = 1'b1;
					state_d         = ST_DONE;
				end else begin
					cmd.left_load = 1'b1;
					state_d       = ST_RD_LAST;
				end
			end
			ST_RD_LAST: begin
				cmd.rd_sel = ADDR_LAST;
				state_d    = ST_CHK_LAST;
			end
			ST_CHK_LAST: begin
				if (status.q_ge_rd) begin
					cmd.res_from_rd = 1'b1;
					state_d         = ST_DONE;
				end else begin
					cmd.scan_clear = 1'b1;
					state_d        = ST_RD_SCAN;
				end
			end
			ST_RD_SCAN: begin
				cmd.rd_sel = ADDR_SCAN;
				state_d    = ST_CHK_SCAN;
			end
			ST_CHK_SCAN: begin
				if (status.q_lt_rd || status.scan_at_last) begin
					cmd.right_load = 1'b1;
					state_d        = ST_SEG;
				end else begin
					cmd.left_load = 1'b1;
					cmd.scan_inc  = 1'b1;
					state_d       = ST_RD_SCAN;
				end
			end
			ST_SEG: begin
				if (status.seg_flat) begin
					cmd.res_from_left = 1'b1;
					state_d           = ST_DONE;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_done) begin
					cmd.comp_clear = 1'b1;
					state_d        = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul_go = 1'b1;
				state_d    = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc_go = 1'b1;
				state_d    = status.comp_done ? ST_DONE : ST_MUL;
			end
			ST_DONE: begin
				if (!status.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: src/kci_datapath.sv
// Datapath: key table, search compares, serial divider, blend multiplier and send test.
`timescale 1ns / 1ps
`default_nettype none

module kci_datapath
	import kci_pkg::*;
#(
	parameter int MAX_KEYS = MAX_KEYS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire dp_cmd_t                    cmd,
	output dp_status_t                      status,
	input  wire logic        [KIDX_W-1:0]   key_index,
	input  wire logic        [FRAME_W-1:0]  key_frame,
	input  wire logic                       key_hold,
	input  wire logic signed [VALUE_W-1:0]  key_value_a,
	input  wire logic signed [VALUE_W-1:0]  key_value_b,
	input  wire logic signed [VALUE_W-1:0]  key_value_c,
	input  wire logic signed [QUERY_W-1:0]  query_frame,
	input  wire logic                       force_send,
	input  wire logic        [KCOUNT_W-1:0] key_count,
	input  wire logic                       color_mode,
	input  wire logic                       out_ready,
	output logic                            out_valid,
	output logic signed      [VALUE_W-1:0]  value_a,
	output logic signed      [VALUE_W-1:0]  value_b,
	output logic signed      [VALUE_W-1:0]  value_c,
	output logic                            send_now
);

	localparam int AW       = $clog2(MAX_KEYS);
	localparam int CW       = $clog2(NUM_COMP);
	localparam int DCW      = $clog2(FRAC_W);
	localparam int CMP_W    = QUERY_W + 1;
	localparam int DIFF_W   = VALUE_W + 1;
	localparam int PROD_W   = DIFF_W + FRAC_W + 1;
	localparam int ENTRY_W  = $bits(key_entry_t);
	localparam logic [CW-1:0]  COMP_LAST = CW'(NUM_COMP - 1);
	localparam logic [DCW-1:0] DIV_LAST  = DCW'(FRAC_W - 1);

	// Key table.
	logic [31:0]        kidx_ext;
	logic               ram_we;
	logic [AW-1:0]      waddr;
	logic [AW-1:0]      raddr;
	key_entry_t         wentry;
	logic [ENTRY_W-1:0] rdata;
	key_entry_t         rd_entry;

	// Search.
	logic [31:0]               kc_ext;
	logic [31:0]               n_clamp;
	logic [31:0]               n_m1;
	logic [AW-1:0]             last_idx;
	logic [AW-1:0]             scan_q;
	logic signed [QUERY_W-1:0] q_q;
	logic                      force_q;
	logic signed [CMP_W-1:0]   q_ext;
	logic signed [CMP_W-1:0]   rd_scaled;
	logic signed [CMP_W-1:0]   left_scaled;
	logic signed [CMP_W-1:0]   seg_diff;
	key_entry_t                left_q;
	key_entry_t                right_q;

	// Divider and blend.
	logic [FRAC_W-1:0]          rem_q;
	logic [FRAC_W-1:0]          dq_q;
	logic [DCW-1:0]             div_cnt_q;
	logic [FRAC_W:0]            rem_sh;
	logic [FRAC_W:0]            rem_sub;
	logic                       rem_ge;
	logic [FRAME_W-1:0]         den;
	logic [2*FRAC_W-1:0]        num;
	logic [CW-1:0]              comp_q;
	logic signed [PROD_W-1:0]   prod_s1;
	logic signed [DIFF_W-1:0]   comp_diff;
	logic signed [VALUE_W-1:0]  lv [NUM_COMP];
	logic signed [VALUE_W-1:0]  rv [NUM_COMP];
	logic signed [VALUE_W-1:0]  res_q [NUM_COMP];

	// Output and send state.
	logic                       out_valid_q;
	logic signed [VALUE_W-1:0]  out_q [NUM_COMP];
	logic                       send_q;
	logic signed [VALUE_W-1:0]  last_q [NUM_COMP];
	logic                       has_sent_q;
	logic                       send_d;

	assign kidx_ext = 32'(key_index);
	assign waddr    = kidx_ext[AW-1:0];
	assign ram_we   = cmd.key_write && (kidx_ext < 32'(MAX_KEYS));
	assign wentry   = '{hold: key_hold, frame: key_frame, va: key_value_a,
	                    vb: key_value_b, vc: key_value_c};

	assign kc_ext   = 32'(key_count);
	assign n_clamp  = (kc_ext == 32'd0) ? 32'd1 :
	                  ((kc_ext > 32'(MAX_KEYS)) ? 32'(MAX_KEYS) : kc_ext);
	assign n_m1     = n_clamp - 32'd1;
	assign last_idx = n_m1[AW-1:0];

	always_comb begin
		unique case (cmd.rd_sel)
			ADDR_FIRST: raddr = '0;
			ADDR_LAST:  raddr = last_idx;
			ADDR_SCAN:  raddr = scan_q;
			default:    raddr = scan_q;
		endcase
	end

	kci_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_KEYS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(waddr),
		.wdata(wentry),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign rd_entry    = key_entry_t'(rdata);
	assign q_ext       = CMP_W'(q_q);
	assign rd_scaled   = $signed({2'b00, rd_entry.frame, 8'h00});
	assign left_scaled = $signed({2'b00, left_q.frame, 8'h00});
	assign seg_diff    = q_ext - left_scaled;

	assign status.q_le_rd      = q_ext <= rd_scaled;
	assign status.q_ge_rd      = q_ext >= rd_scaled;
	assign status.q_lt_rd      = q_ext < rd_scaled;
	assign status.scan_at_last = scan_q == last_idx;
	assign status.seg_flat     = left_q.hold || (right_q.frame <= left_q.frame);
	assign status.div_done     = div_cnt_q == DIV_LAST;
	assign status.comp_done    = comp_q == COMP_LAST;
	assign status.out_busy     = out_valid_q && !out_ready;

	always_ff @(posedge clk) begin
		if (cmd.query_load) begin
			q_q     <= query_frame;
			force_q <= force_send;
		end
		if (cmd.left_load) begin
			left_q <= rd_entry;
		end
		if (cmd.right_load) begin
			right_q <= rd_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q    <= '0;
			div_cnt_q <= '0;
			comp_q    <= '0;
		end else begin
			if (cmd.scan_clear) begin
				scan_q <= AW'(1);
			end else if (cmd.scan_inc) begin
				scan_q <= scan_q + AW'(1);
			end
			if (cmd.div_start) begin
				div_cnt_q <= '0;
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q + DCW'(1);
			end
			if (cmd.comp_clear) begin
				comp_q <= '0;
			end else if (cmd.acc_go) begin
				comp_q <= comp_q + CW'(1);
			end
		end
	end

	// Restoring divider: the dividend is below den * 2^16, so the quotient fits 16 bits.
	assign den     = right_q.frame - left_q.frame;
	assign num     = {seg_diff[23:0], 8'h00};
	assign rem_sh  = {rem_q, dq_q[FRAC_W-1]};
	assign rem_ge  = rem_sh >= {1'b0, den};
	assign rem_sub = rem_sh - {1'b0, den};

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			rem_q <= num[2*FRAC_W-1:FRAC_W];
			dq_q  <= num[FRAC_W-1:0];
		end else if (cmd.div_step) begin
			rem_q <= rem_ge ? rem_sub[FRAC_W-1:0] : rem_sh[FRAC_W-1:0];
			dq_q  <= {dq_q[FRAC_W-2:0], rem_ge};
		end
	end

	always_comb begin
		lv[0] = left_q.va;
		lv[1] = left_q.vb;
		lv[2] = left_q.vc;
		rv[0] = right_q.va;
		rv[1] = right_q.vb;
		rv[2] = right_q.vc;
	end

	assign comp_diff = DIFF_W'(rv[comp_q]) - DIFF_W'(lv[comp_q]);

	always_ff @(posedge clk) begin
		if (cmd.mul_go) begin
			prod_s1 <= comp_diff * $signed({1'b0, dq_q});
		end
		if (cmd.acc_go) begin
			res_q[comp_q] <= lv[comp_q] + prod_s1[FRAC_W+VALUE_W-1:FRAC_W];
		end else if (cmd.res_from_rd) begin
			res_q[0] <= rd_entry.va;
			res_q[1] <= rd_entry.vb;
			res_q[2] <= rd_entry.vc;
		end else if (cmd.res_from_left) begin
			res_q[0] <= left_q.va;
			res_q[1] <= left_q.vb;
			res_q[2] <= left_q.vc;
		end
	end

	assign send_d = force_q || !has_sent_q || (res_q[0] != last_q[0]) ||
	                (color_mode && ((res_q[1] != last_q[1]) || (res_q[2] != last_q[2])));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			has_sent_q  <= 1'b0;
			last_q[0]   <= '0;
			last_q[1]   <= '0;
			last_q[2]   <= '0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.out_load && send_d) begin
				has_sent_q <= 1'b1;
				last_q[0]  <= res_q[0];
				if (color_mode) begin
					last_q[1] <= res_q[1];
					last_q[2] <= res_q[2];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q[0] <= res_q[0];
			out_q[1] <= res_q[1];
			out_q[2] <= res_q[2];
			send_q   <= send_d;
		end
	end

	assign out_valid = out_valid_q;
	assign value_a   = out_q[0];
	assign value_b   = out_q[1];
	assign value_c   = out_q[2];
	assign send_now  = send_q;

endmodule

`default_nettype wire
